// ----- design/xrg_pkg.sv -----
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared constants, types and job format of the xoshiro128** range generator.
// ----------------------------------------------------------------------------
package xrg_pkg;

	localparam int unsigned NUM_WORDS   = 4;
	localparam int unsigned WORD_IDX_W  = $clog2(NUM_WORDS);
	localparam int unsigned DIV_STEPS   = 32;
	localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] MIX_ADD    = 32'h9E37_79B9;
	localparam logic [31:0] MIX_MUL1   = 32'h85EB_CA6B;
	localparam logic [31:0] MIX_MUL2   = 32'hC2B2_AE35;
	localparam logic [31:0] OUT_MUL1   = 32'd5;
	localparam logic [31:0] OUT_MUL2   = 32'd9;
	localparam logic [31:0] RESET_SEED = 32'd1234;

	localparam logic FUNC_RAW   = 1'b0;
	localparam logic FUNC_RANGE = 1'b1;

	typedef enum logic [2:0] {
		SEED_ADD,
		SEED_MUL1,
		SEED_MUL2,
		SEED_STORE,
		GEN_RUN
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} back_state_t;

	typedef enum logic [1:0] {
		KIND_RAW,
		KIND_FIXED,
		KIND_RANGE
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] raw;
		logic [31:0] lo;
		logic [32:0] span;
	} job_t;

endpackage

// ----- design/xrg_front.sv -----
// ----------------------------------------------------------------------------
// xrg_front
// Seeds the generator state, takes requests, draws and classifies them.
// ----------------------------------------------------------------------------
module xrg_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seed_we,
	input  logic [31:0]         seed_value,
	input  logic                push,
	input  logic                func,
	input  logic signed [31:0]  range_low,
	input  logic signed [31:0]  range_high,
	output logic                full,
	input  logic                q_full,
	output logic                q_push,
	output xrg_pkg::job_t       q_job
);
	import xrg_pkg::*;

	front_state_t           state_q, state_d;
	logic [WORD_IDX_W-1:0]  round_q;
	logic [31:0]            sd_q;
	logic [31:0]            z_q;
	logic [31:0]            gen_q [NUM_WORDS];

	logic        accept;
	logic        ordered;
	logic        advance;
	logic [31:0] mul5;
	logic [31:0] rot7;
	logic [31:0] draw_res;
	logic [31:0] t0, t1, t2, t3;
	logic [32:0] span;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
		rotl32 = (x << k) | (x >> (32 - k));
	endfunction

	assign full     = (state_q != GEN_RUN) || q_full;
	assign accept   = push && !full;
	assign ordered  = range_high > range_low;
	assign advance  = (func == FUNC_RAW) || ordered;
	assign q_push   = accept;

	assign mul5     = gen_q[1] * OUT_MUL1;
	assign rot7     = rotl32(mul5, 7);
	assign draw_res = rot7 * OUT_MUL2;

	// next generator words
	assign t2 = gen_q[2] ^ gen_q[0];
	assign t3 = gen_q[3] ^ gen_q[1];
	assign t1 = gen_q[1] ^ t2;
	assign t0 = gen_q[0] ^ t3;

	assign span = {range_high[31], range_high} - {range_low[31], range_low} + 33'd1;

	always_comb begin
		q_job.raw  = draw_res;
		q_job.lo   = range_low;
		q_job.span = span;
		if (func == FUNC_RAW) begin
			q_job.kind = KIND_RAW;
		end else if (ordered) begin
			q_job.kind = KIND_RANGE;
		end else begin
			q_job.kind = KIND_FIXED;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEED_ADD:   state_d = SEED_MUL1;
			SEED_MUL1:  state_d = SEED_MUL2;
			SEED_MUL2:  state_d = SEED_STORE;
			SEED_STORE: state_d = (round_q == WORD_IDX_W'(NUM_WORDS - 1)) ? GEN_RUN : SEED_ADD;
			GEN_RUN:    state_d = GEN_RUN;
			default:    state_d = SEED_ADD;
		endcase
		if (seed_we) begin
			state_d = SEED_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEED_ADD;
			round_q <= '0;
			sd_q    <= RESET_SEED;
		end else begin
			state_q <= state_d;
			if (seed_we) begin
				round_q <= '0;
				sd_q    <= seed_value;
			end else begin
				if (state_q == SEED_STORE) begin
					round_q <= round_q + 1'b1;
				end
				if (state_q == SEED_ADD) begin
					sd_q <= sd_q + MIX_ADD;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SEED_MUL1: z_q <= (sd_q ^ (sd_q >> 15)) * MIX_MUL1;
			SEED_MUL2: z_q <= (z_q ^ (z_q >> 13)) * MIX_MUL2;
			default:   z_q <= z_q;
		endcase
		if (state_q == SEED_STORE && !seed_we) begin
			gen_q[round_q] <= z_q ^ (z_q >> 16);
		end
		if (accept && advance) begin
			gen_q[0] <= t0;
			gen_q[1] <= t1;
			gen_q[2] <= t2 ^ (gen_q[1] << 9);
			gen_q[3] <= rotl32(t3, 11);
		end
	end

	a_no_push_while_seeding: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != GEN_RUN) |-> !q_push)
		else $error("request taken while seeding");

	a_seed_ends_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEED_STORE && round_q == WORD_IDX_W'(NUM_WORDS - 1) && !seed_we)
		|=> state_q == GEN_RUN)
		else $error("seeding did not finish after last word");

	a_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		seed_we |=> (state_q == SEED_ADD && round_q == '0))
		else $error("seed write did not restart mixing");

endmodule

// ----- design/xrg_fifo.sv -----
// ----------------------------------------------------------------------------
// xrg_fifo
// Short job queue between the draw front and the modulo back.
// ----------------------------------------------------------------------------
module xrg_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xrg_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output xrg_pkg::job_t head
);
	import xrg_pkg::*;

	job_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full  = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("job queue underflow");

endmodule

// ----- design/xrg_back.sv -----
// ----------------------------------------------------------------------------
// xrg_back
// Passes raw and single-value jobs through, reduces ranged draws by a bit-serial modulo, and holds the result word.
// ----------------------------------------------------------------------------
module xrg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  xrg_pkg::job_t       q_head,
	output logic                q_pop,
	output logic                empty,
	input  logic                pop,
	output logic signed [32:0]  value
);
	import xrg_pkg::*;

	back_state_t          bstate_q, bstate_d;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          dvd_q;
	logic [32:0]          span_q;
	logic [32:0]          rem_q;
	logic [31:0]          lo_q;
	logic                 out_valid_q;
	logic [32:0]          value_q;

	logic        slot_free;
	logic        out_load;
	logic [32:0] out_d;
	logic        div_start;
	logic [33:0] trial;
	logic [33:0] span_ext;
	logic        fits;

	assign slot_free = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign value     = value_q;

	assign trial    = {rem_q, dvd_q[31]};
	assign span_ext = {1'b0, span_q};
	assign fits     = trial >= span_ext;

	always_comb begin
		bstate_d  = bstate_q;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		div_start = 1'b0;
		out_d     = {1'b0, q_head.raw};
		case (bstate_q)
			B_IDLE: begin
				if (!q_empty && slot_free) begin
					q_pop = 1'b1;
					case (q_head.kind)
						KIND_RANGE: begin
							div_start = 1'b1;
							bstate_d  = B_DIV;
						end
						KIND_FIXED: begin
							out_load = 1'b1;
							out_d    = {q_head.lo[31], q_head.lo};
						end
						default: begin
							out_load = 1'b1;
							out_d    = {1'b0, q_head.raw};
						end
					endcase
				end
			end
			B_DIV: begin
				if (cnt_q == '0) begin
					bstate_d = B_DONE;
				end
			end
			B_DONE: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d    = {lo_q[31], lo_q} + {1'b0, rem_q[31:0]};
					bstate_d = B_IDLE;
				end
			end
			default: bstate_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q    <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			bstate_q    <= bstate_d;
			out_valid_q <= out_load || (out_valid_q && !pop);
			if (div_start) begin
				cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (bstate_q == B_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= out_d;
		end
		if (div_start) begin
			dvd_q  <= q_head.raw;
			span_q <= q_head.span;
			lo_q   <= q_head.lo;
			rem_q  <= '0;
		end else if (bstate_q == B_DIV) begin
			dvd_q <= dvd_q << 1;
			rem_q <= fits ? 33'(trial - span_ext) : trial[32:0];
		end
	end

	a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(bstate_q != B_IDLE) |-> !q_pop)
		else $error("job taken while modulo busy");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(bstate_q == B_DIV && cnt_q == '0) |=> bstate_q == B_DONE)
		else $error("modulo did not finish after last step");

	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		(bstate_q == B_DONE) |-> rem_q < span_q)
		else $error("remainder not below span");

endmodule

// ----- design/xoshiro128ss_range_generator.sv -----
// ----------------------------------------------------------------------------
// xoshiro128ss_range_generator
// xoshiro128** generator with raw and ranged draws, seeded by mixing rounds.
//
//   channel  | handshake      | words
//   ---------+----------------+---------------------------------
//   request  | push / full    | func, range_low, range_high
//   result   | pop / empty    | value
//   seed     | seed_we        | seed_value
//
// raw and single-value requests: one per cycle while full is low, result word via the job queue and result register
// ranged requests: reduced by the 32-step bit-serial modulo, which takes a new job only when the last one is out
// seeding after reset and after each seed write: one mixing round per state word, full held high
// a two-entry job queue lets the front keep drawing while the modulo runs
// ----------------------------------------------------------------------------
module xoshiro128ss_range_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               seed_we,
	input  logic [31:0]        seed_value,
	input  logic               push,
	output logic               full,
	input  logic               func,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	output logic               empty,
	input  logic               pop,
	output logic signed [32:0] value
);
	import xrg_pkg::*;

	logic q_full;
	logic q_push;
	logic q_empty;
	logic q_pop;
	job_t push_job;
	job_t head_job;

	xrg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_value (seed_value),
		.push       (push),
		.func       (func),
		.range_low  (range_low),
		.range_high (range_high),
		.full       (full),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	xrg_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	xrg_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (head_job),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.value   (value)
	);

endmodule
